### sv/rot_pkg.sv
// shared constants and types for the axis rotation core
`default_nettype none
package rot_pkg;

    localparam int MUL_CH  = 32;
    localparam int MUL_LAT = 3;
    localparam int TOL_W   = 16;

    typedef struct packed {
        logic neg;
        logic big;
    } t_div_tag;

endpackage
`default_nettype wire

### sv/rotate_about_axis_core.sv
// top level: rotates a vector about an arbitrary axis, one request per cycle while the skid stage is empty
// throughput: one request per cycle while the skid stage is empty, set by the fully pipelined
//   multipliers, the square root cell chain (COMP_WIDTH+FRAC_BITS cells) and divider chain
// output register plus skid stage keep input ready free of any combinational path from output ready
// reset: synchronous active low, clears valid flags and sets tolerance to 1
`default_nettype none
module rotate_about_axis_core #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COMP_WIDTH-1:0]  i_vec_x,
    input  logic signed [COMP_WIDTH-1:0]  i_vec_y,
    input  logic signed [COMP_WIDTH-1:0]  i_vec_z,
    input  logic signed [COMP_WIDTH-1:0]  i_axis_x,
    input  logic signed [COMP_WIDTH-1:0]  i_axis_y,
    input  logic signed [COMP_WIDTH-1:0]  i_axis_z,
    input  logic signed [FRAC_BITS+1:0]   i_cos_angle,
    input  logic signed [FRAC_BITS+1:0]   i_sin_angle,
    input  logic                          i_cfg_we,
    input  logic [rot_pkg::TOL_W-1:0]     i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COMP_WIDTH-1:0]  o_out_x,
    output logic signed [COMP_WIDTH-1:0]  o_out_y,
    output logic signed [COMP_WIDTH-1:0]  o_out_z,
    output logic                          o_passed_through
);
    import rot_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int FW   = FRAC_BITS;
    localparam int AW   = FW + 2;
    localparam int KW   = AW + 1;
    localparam int PW   = 2 * CW;
    localparam int NW   = 2 * CW + 1;
    localparam int CXW  = 2 * CW + 1;
    localparam int DW   = 2 * CW + 2;
    localparam int CCW  = 2 * CXW + 2;
    localparam int TTW  = 2 * TOL_W;
    localparam int TNW  = TTW + 1 + NW;
    localparam int CMW  = (CCW > TNW) ? CCW : TNW;
    localparam int KAW  = KW + CW;
    localparam int CVW  = AW + CW;
    localparam int T1W  = KAW + DW;
    localparam int T2W  = CVW + NW;
    localparam int T12W = T1W + 1;
    localparam int SCW  = AW + CXW;
    localparam int T3PW = SCW + NW;
    localparam int T3W  = T3PW + FW;
    localparam int RW   = CW + FW;
    localparam int PRW  = T12W + RW + 1;
    localparam int NUMW = PRW + 1;
    localparam int NRW  = NW + RW + 1;
    localparam int DENW = NRW + FW;
    localparam int QB   = CW + 2;
    localparam int RMW  = DENW + QB;
    localparam int DDW  = RMW - 1;
    localparam int BGW  = NUMW + 1;
    localparam int RESW = 3 * CW + 1;

    localparam int ST_B = MUL_LAT + 1;
    localparam int ST_C = ST_B + MUL_LAT;
    localparam int ST_D = ST_C + 1;
    localparam int ST_E = ST_D + 1;
    localparam int SR   = ST_B + RW;
    localparam int ST_I = SR + MUL_LAT + 3;
    localparam int P    = ST_I + QB;

    localparam logic signed [KW-1:0] ONE_F = KW'(1) << FW;
    localparam logic [QB-1:0]        LIM   = QB'(1) << (CW - 1);
    localparam logic [QB-1:0]        LIMM1 = LIM - QB'(1);

    // control
    logic                 w_en;
    logic                 w_acc;
    logic [P-1:0]         r_vld;
    logic                 w_pvld;
    logic [TOL_W-1:0]     r_tol;
    logic [TTW-1:0]       r_tt;

    // stage 0 operands
    logic signed [CW-1:0] w_a [3];
    logic signed [CW-1:0] w_v [3];
    logic signed [KW-1:0] w_k;

    // first multiplier rank
    logic signed [PW-1:0]  w_sq [3];
    logic signed [PW-1:0]  w_xa [3];
    logic signed [PW-1:0]  w_xb [3];
    logic signed [PW-1:0]  w_dt [3];
    logic signed [KAW-1:0] w_ka [3];
    logic signed [CVW-1:0] w_cv [3];
    logic [AW-1:0]         w_snd;

    logic signed [NW-1:0]  r_n;
    logic signed [CXW-1:0] r_c [3];
    logic signed [DW-1:0]  r_d;
    logic signed [KAW-1:0] r_ka [3];
    logic signed [CVW-1:0] r_cv [3];
    logic                  r_nsmall;
    logic [0:0]            w_nsmall_d;

    // second multiplier rank
    logic signed [2*CXW-1:0] w_cc [3];
    logic signed [TNW-1:0]   w_ttn;
    logic signed [T1W-1:0]   w_t1 [3];
    logic signed [T2W-1:0]   w_t2 [3];
    logic signed [SCW-1:0]   w_sc [3];
    logic signed [CCW-1:0]   r_cc;
    logic signed [TNW-1:0]   r_ttn;
    logic signed [T12W-1:0]  r_t12 [3];
    logic                    r_pass;
    logic [0:0]              w_pass_d;
    logic [NW-1:0]           w_nc;
    logic [NW-1:0]           w_nr;

    // third rank and square root
    logic signed [T3PW-1:0] w_t3p [3];
    logic [T3W-1:0]         w_t3d [3];
    logic [T12W-1:0]        w_t12d [3];
    logic [2*RW-1:0]        w_sx [RW+1];
    logic [RW+1:0]          w_srem [RW+1];
    logic [RW-1:0]          w_sroot [RW+1];

    // fourth rank and divider prep
    logic signed [PRW-1:0]  w_pr [3];
    logic signed [NRW-1:0]  w_nrr;
    logic signed [NUMW-1:0] r_num [3];
    logic [DENW-1:0]        r_den;
    logic [BGW-1:0]         r_mag2 [3];
    logic                   r_neg [3];
    logic [DENW-1:0]        r_den2;
    logic [RMW-1:0]         r_rem0 [3];
    logic [DDW-1:0]         r_dd0;
    t_div_tag               r_tag0 [3];

    // divider chains
    logic [RMW-1:0] w_drem [3][QB+1];
    logic [DDW-1:0] w_ddd  [3][QB+1];
    logic [QB-1:0]  w_dq   [3][QB+1];
    t_div_tag       w_dtag [3][QB+1];

    // final stage
    logic [3*CW-1:0]      w_vecd;
    logic [QB:0]          w_q1 [3];
    logic [QB-1:0]        w_qr [3];
    logic [QB-1:0]        w_m [3];
    logic signed [CW-1:0] w_res [3];
    logic [RESW-1:0]      w_pipe;
    logic                 r_ovld;
    logic                 r_svld;
    logic [RESW-1:0]      r_odata;
    logic [RESW-1:0]      r_sdata;

    assign w_en       = !r_svld;
    assign w_acc      = i_in_valid && w_en;
    assign o_in_ready = w_en;
    assign w_pvld     = r_vld[P-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
            r_tt  <= TTW'(1);
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            r_tt <= TTW'(r_tol) * TTW'(r_tol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[P-2:0], w_acc};
        end
    end

    assign w_a[0] = i_axis_x;
    assign w_a[1] = i_axis_y;
    assign w_a[2] = i_axis_z;
    assign w_v[0] = i_vec_x;
    assign w_v[1] = i_vec_y;
    assign w_v[2] = i_vec_z;
    assign w_k    = ONE_F - KW'(i_cos_angle);

    rot_delay #(.W(AW), .LEN(ST_B)) u_sin_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(i_sin_angle), .o_q(w_snd)
    );

    rot_delay #(.W(3*CW), .LEN(P)) u_vec_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d({i_vec_x, i_vec_y, i_vec_z}), .o_q(w_vecd)
    );

    for (genvar i = 0; i < 3; i++) begin : g_rank1
        rot_mul #(.WA(CW), .WB(CW)) u_sq (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_a[i]), .i_b(w_a[i]), .o_p(w_sq[i])
        );
        rot_mul #(.WA(CW), .WB(CW)) u_xa (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_a[(i+1)%3]), .i_b(w_v[(i+2)%3]),
            .o_p(w_xa[i])
        );
        rot_mul #(.WA(CW), .WB(CW)) u_xb (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_a[(i+2)%3]), .i_b(w_v[(i+1)%3]),
            .o_p(w_xb[i])
        );
        rot_mul #(.WA(CW), .WB(CW)) u_dt (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_a[i]), .i_b(w_v[i]), .o_p(w_dt[i])
        );
        rot_mul #(.WA(KW), .WB(CW)) u_ka (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_k), .i_b(w_a[i]), .o_p(w_ka[i])
        );
        rot_mul #(.WA(AW), .WB(CW)) u_cv (
            .i_clk(i_clk), .i_en(w_en), .i_a(i_cos_angle), .i_b(w_v[i]), .o_p(w_cv[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n <= NW'(w_sq[0]) + NW'(w_sq[1]) + NW'(w_sq[2]);
            r_d <= DW'(w_dt[0]) + DW'(w_dt[1]) + DW'(w_dt[2]);
            for (int i = 0; i < 3; i++) begin
                r_c[i]  <= CXW'(w_xa[i]) - CXW'(w_xb[i]);
                r_ka[i] <= w_ka[i];
                r_cv[i] <= w_cv[i];
            end
            r_nsmall <= (r_n == '0) || (r_n < $signed(NW'(r_tt)));
        end
    end

    rot_delay #(.W(1), .LEN(MUL_LAT)) u_nsmall_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_nsmall), .o_q(w_nsmall_d)
    );

    rot_mul #(.WA(TTW+1), .WB(NW)) u_ttn (
        .i_clk(i_clk), .i_en(w_en), .i_a($signed({1'b0, r_tt})), .i_b(r_n), .o_p(w_ttn)
    );

    for (genvar i = 0; i < 3; i++) begin : g_rank2
        rot_mul #(.WA(CXW), .WB(CXW)) u_cc (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_c[i]), .i_b(r_c[i]), .o_p(w_cc[i])
        );
        rot_mul #(.WA(KAW), .WB(DW)) u_t1 (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_ka[i]), .i_b(r_d), .o_p(w_t1[i])
        );
        rot_mul #(.WA(CVW), .WB(NW)) u_t2 (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_cv[i]), .i_b(r_n), .o_p(w_t2[i])
        );
        rot_mul #(.WA(AW), .WB(CXW)) u_sc (
            .i_clk(i_clk), .i_en(w_en), .i_a($signed(w_snd)), .i_b(r_c[i]), .o_p(w_sc[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc  <= CCW'(w_cc[0]) + CCW'(w_cc[1]) + CCW'(w_cc[2]);
            r_ttn <= w_ttn;
            for (int i = 0; i < 3; i++) begin
                r_t12[i] <= T12W'(w_t1[i]) + T12W'(w_t2[i]);
            end
            r_pass <= w_nsmall_d[0] || (CMW'(r_cc) < CMW'(r_ttn));
        end
    end

    rot_delay #(.W(1), .LEN(P-ST_E)) u_pass_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_pass), .o_q(w_pass_d)
    );

    rot_delay #(.W(NW), .LEN(MUL_LAT)) u_nc_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_n), .o_q(w_nc)
    );

    rot_delay #(.W(NW), .LEN(RW)) u_nr_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_n), .o_q(w_nr)
    );

    for (genvar i = 0; i < 3; i++) begin : g_rank3
        rot_mul #(.WA(SCW), .WB(NW)) u_t3 (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_sc[i]), .i_b($signed(w_nc)), .o_p(w_t3p[i])
        );
        rot_delay #(.W(T3W), .LEN(RW-MUL_LAT)) u_t3_dly (
            .i_clk(i_clk), .i_en(w_en), .i_d({w_t3p[i], {FW{1'b0}}}), .o_q(w_t3d[i])
        );
        rot_delay #(.W(T12W), .LEN(RW-MUL_LAT-1)) u_t12_dly (
            .i_clk(i_clk), .i_en(w_en), .i_d(r_t12[i]), .o_q(w_t12d[i])
        );
    end

    // square root of n scaled by 2^(2*frac)
    assign w_sx[0]    = {r_n[PW-1:0], {(2*FW){1'b0}}};
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        rot_sqrt_cell #(.RW(RW)) u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(w_sx[k]), .i_rem(w_srem[k]), .i_root(w_sroot[k]),
            .o_x(w_sx[k+1]), .o_rem(w_srem[k+1]), .o_root(w_sroot[k+1])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_rank4
        rot_mul #(.WA(T12W), .WB(RW+1)) u_pr (
            .i_clk(i_clk), .i_en(w_en), .i_a($signed(w_t12d[i])),
            .i_b($signed({1'b0, w_sroot[RW]})), .o_p(w_pr[i])
        );
    end

    rot_mul #(.WA(NW), .WB(RW+1)) u_nrr (
        .i_clk(i_clk), .i_en(w_en), .i_a($signed(w_nr)),
        .i_b($signed({1'b0, w_sroot[RW]})), .o_p(w_nrr)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den  <= {$unsigned(w_nrr), {FW{1'b0}}};
            r_den2 <= r_den;
            r_dd0  <= DDW'(r_den2) << (QB - 1);
            for (int i = 0; i < 3; i++) begin
                r_num[i]      <= NUMW'(w_pr[i]) + NUMW'($signed(w_t3d[i]));
                r_neg[i]      <= r_num[i][NUMW-1];
                r_mag2[i]     <= {(r_num[i][NUMW-1] ? $unsigned(NUMW'(-r_num[i]))
                                                    : $unsigned(r_num[i])), 1'b0};
                r_rem0[i]     <= r_mag2[i][RMW-1:0];
                r_tag0[i].neg <= r_neg[i];
                r_tag0[i].big <= r_mag2[i] >= (BGW'(r_den2) << QB);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        assign w_drem[i][0] = r_rem0[i];
        assign w_ddd[i][0]  = r_dd0;
        assign w_dq[i][0]   = '0;
        assign w_dtag[i][0] = r_tag0[i];

        for (genvar k = 0; k < QB; k++) begin : g_cell
            rot_div_cell #(.RMW(RMW), .QB(QB)) u_cell (
                .i_clk(i_clk), .i_en(w_en),
                .i_rem(w_drem[i][k]), .i_dd(w_ddd[i][k]),
                .i_q(w_dq[i][k]), .i_tag(w_dtag[i][k]),
                .o_rem(w_drem[i][k+1]), .o_dd(w_ddd[i][k+1]),
                .o_q(w_dq[i][k+1]), .o_tag(w_dtag[i][k+1])
            );
        end

        // round half away from zero, then saturate
        assign w_q1[i] = (QB+1)'(w_dq[i][QB]) + (QB+1)'(1);
        assign w_qr[i] = w_q1[i][QB:1];

        always_comb begin
            if (w_dtag[i][QB].neg) begin
                w_m[i] = (w_dtag[i][QB].big || (w_qr[i] > LIM)) ? LIM : w_qr[i];
                w_res[i] = $signed(CW'(QB'(0) - w_m[i]));
            end else begin
                w_m[i] = (w_dtag[i][QB].big || (w_qr[i] > LIMM1)) ? LIMM1 : w_qr[i];
                w_res[i] = $signed(CW'(w_m[i]));
            end
        end
    end

    assign w_pipe = w_pass_d[0] ? {1'b1, w_vecd}
                                : {1'b0, w_res[0], w_res[1], w_res[2]};

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (r_ovld && !i_out_ready) begin
            if (w_en && w_pvld) begin
                r_svld <= 1'b1;
            end
        end else if (r_svld) begin
            r_ovld <= 1'b1;
            r_svld <= 1'b0;
        end else begin
            r_ovld <= w_pvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ovld && !i_out_ready) begin
            if (w_en && w_pvld) begin
                r_sdata <= w_pipe;
            end
        end else if (r_svld) begin
            r_odata <= r_sdata;
        end else begin
            r_odata <= w_pipe;
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_passed_through = r_odata[RESW-1];
    assign o_out_x          = $signed(r_odata[3*CW-1:2*CW]);
    assign o_out_y          = $signed(r_odata[2*CW-1:CW]);
    assign o_out_z          = $signed(r_odata[CW-1:0]);

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_svld) |-> $past(r_ovld && !i_out_ready))
        else $error("skid filled while output was free");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svld |-> r_ovld)
        else $error("skid holds a request without a held output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear output and skid");

endmodule
`default_nettype wire

### sv/rot_delay.sv
// register shift line that carries side data along the pipeline
`default_nettype none
module rot_delay #(
    parameter int W   = 1,
    parameter int LEN = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [LEN];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < LEN; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[LEN-1];

endmodule
`default_nettype wire

### sv/rot_mul.sv
// three stage signed multiplier built from chunked unsigned partial products
`default_nettype none
module rot_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [WA-1:0]  i_a,
    input  logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import rot_pkg::*;

    localparam int NA = (WA + MUL_CH - 1) / MUL_CH;
    localparam int NB = (WB + MUL_CH - 1) / MUL_CH;
    localparam int PW = WA + WB;
    localparam int SW = (NA + NB) * MUL_CH;

    logic [WA-1:0]          w_ma;
    logic [WB-1:0]          w_mb;
    logic [NA*MUL_CH-1:0]   r_ma;
    logic [NB*MUL_CH-1:0]   r_mb;
    logic                   r_neg1;
    logic                   r_neg2;
    logic [2*MUL_CH-1:0]    r_pp [NA][NB];
    logic [SW-1:0]          w_sum;
    logic signed [PW-1:0]   r_p;

    assign w_ma = i_a[WA-1] ? $unsigned(WA'(-i_a)) : $unsigned(i_a);
    assign w_mb = i_b[WB-1] ? $unsigned(WB'(-i_b)) : $unsigned(i_b);

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_sum = w_sum + (SW'(r_pp[i][j]) << (MUL_CH * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= (NA*MUL_CH)'(w_ma);
            r_mb   <= (NB*MUL_CH)'(w_mb);
            r_neg1 <= i_a[WA-1] ^ i_b[WB-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= (2*MUL_CH)'(r_ma[i*MUL_CH +: MUL_CH])
                                * (2*MUL_CH)'(r_mb[j*MUL_CH +: MUL_CH]);
                end
            end
            r_neg2 <= r_neg1;
            r_p    <= r_neg2 ? -$signed(w_sum[PW-1:0]) : $signed(w_sum[PW-1:0]);
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### sv/rot_sqrt_cell.sv
// one digit step of the floor square root chain
`default_nettype none
module rot_sqrt_cell #(
    parameter int RW = 48
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_x,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    output logic [2*RW-1:0] o_x,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root
);

    logic [RW+3:0]   w_t;
    logic [RW+3:0]   w_trial;
    logic [RW+3:0]   w_d;
    logic            w_ge;
    logic [2*RW-1:0] r_x;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;

    assign w_t     = {i_rem, i_x[2*RW-1 -: 2]};
    assign w_trial = (RW+4)'({i_root, 2'b01});
    assign w_ge    = w_t >= w_trial;
    assign w_d     = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= i_x << 2;
            r_rem  <= w_ge ? w_d[RW+1:0] : w_t[RW+1:0];
            r_root <= {i_root[RW-2:0], w_ge};
        end
    end

    assign o_x    = r_x;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

### sv/rot_div_cell.sv
// one quotient bit step of the restoring divider chain
`default_nettype none
module rot_div_cell #(
    parameter int RMW = 164,
    parameter int QB  = 34
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RMW-1:0]    i_rem,
    input  logic [RMW-2:0]    i_dd,
    input  logic [QB-1:0]     i_q,
    input  rot_pkg::t_div_tag i_tag,
    output logic [RMW-1:0]    o_rem,
    output logic [RMW-2:0]    o_dd,
    output logic [QB-1:0]     o_q,
    output rot_pkg::t_div_tag o_tag
);
    import rot_pkg::*;

    logic [RMW-1:0] w_d;
    logic [RMW-1:0] w_n;
    logic           w_ge;
    logic [RMW-1:0] r_rem;
    logic [RMW-2:0] r_dd;
    logic [QB-1:0]  r_q;
    t_div_tag       r_tag;

    assign w_ge = i_rem >= {1'b0, i_dd};
    assign w_d  = i_rem - {1'b0, i_dd};
    assign w_n  = w_ge ? w_d : i_rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= {w_n[RMW-2:0], 1'b0};
            r_dd  <= i_dd;
            r_q   <= {i_q[QB-2:0], w_ge};
            r_tag <= i_tag;
        end
    end

    assign o_rem = r_rem;
    assign o_dd  = r_dd;
    assign o_q   = r_q;
    assign o_tag = r_tag;

endmodule
`default_nettype wire

### tb/sv/rotate_about_axis_core_tb.sv
// testbench for rotate_about_axis_core: exact-arithmetic prediction and in-order result check
`default_nettype none
module rotate_about_axis_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int CW = 32;
    localparam int AW = FB + 2;
    localparam int PIPE_LAT = 2 * CW + FB + 13;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] vec [3];
        logic signed [CW-1:0] axis [3];
        logic signed [AW-1:0] cos_a;
        logic signed [AW-1:0] sin_a;
    } rot_req_t;

    typedef struct {
        logic signed [CW-1:0] comp [3];
        logic                 passed;
    } rot_res_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [CW-1:0]      i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic signed [CW-1:0]      i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic signed [AW-1:0]      i_cos_angle = '0, i_sin_angle = '0;
    logic                      i_cfg_we = 1'b0;
    logic [rot_pkg::TOL_W-1:0] i_cfg_wdata = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [CW-1:0]      o_out_x, o_out_y, o_out_z;
    logic                      o_passed_through;

    rot_res_t                  rotated_q [$];
    logic [rot_pkg::TOL_W-1:0] tolerance = 1;
    int                        errors = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    int                        hold_cycles = 0;

    rotate_about_axis_core #(.FRAC_BITS(FB), .COMP_WIDTH(CW)) dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_vec_x, .i_vec_y, .i_vec_z, .i_axis_x, .i_axis_y, .i_axis_z,
        .i_cos_angle, .i_sin_angle, .i_cfg_we, .i_cfg_wdata,
        .o_out_valid, .i_out_ready, .o_out_x, .o_out_y, .o_out_z, .o_passed_through
    );

    always #10 i_clk = ~i_clk;

    function automatic logic signed [CW-1:0] round_saturate(input wide_t num, input wide_t den);
        wide_t mag, quo, rem;
        wide_t lim;
        logic  neg;
        lim = 256'sd2147483648;
        neg = num[255];
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem <<< 1) >= den)
            quo = quo + 1;
        if (neg) begin
            if (quo > lim)
                quo = lim;
            quo = -quo;
        end else if (quo > lim - 1) begin
            quo = lim - 1;
        end
        return quo[CW-1:0];
    endfunction

    function automatic rot_res_t rotate_vector(input rot_req_t q);
        rot_res_t res;
        wide_t    v [3], a [3], c [3];
        wide_t    n, d, cc, tt, one, r, t, k, den, cs, sn, num;
        for (int i = 0; i < 3; i++) begin
            v[i] = q.vec[i];
            a[i] = q.axis[i];
        end
        cs = q.cos_a;
        sn = q.sin_a;
        tt = tolerance;
        tt = tt * tt;
        n = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        c[0] = a[1] * v[2] - a[2] * v[1];
        c[1] = a[2] * v[0] - a[0] * v[2];
        c[2] = a[0] * v[1] - a[1] * v[0];
        cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        if (n == 0 || n < tt || cc < tt * n) begin
            for (int i = 0; i < 3; i++)
                res.comp[i] = q.vec[i];
            res.passed = 1'b1;
            return res;
        end
        d = a[0] * v[0] + a[1] * v[1] + a[2] * v[2];
        one = 65536;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (wide_t'(1) <<< b);
            if (t * t <= n * one * one)
                r = t;
        end
        k = one - cs;
        den = one * n * r;
        for (int i = 0; i < 3; i++) begin
            num = (k * a[i] * d + cs * v[i] * n) * r + sn * c[i] * one * n;
            res.comp[i] = round_saturate(num, den);
        end
        res.passed = 1'b0;
        return res;
    endfunction

    task automatic send_request(input rot_req_t q);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        {i_vec_x, i_vec_y, i_vec_z} = {q.vec[0], q.vec[1], q.vec[2]};
        {i_axis_x, i_axis_y, i_axis_z} = {q.axis[0], q.axis[1], q.axis[2]};
        i_cos_angle = q.cos_a;
        i_sin_angle = q.sin_a;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        rotated_q.push_back(rotate_vector(q));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (rotated_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 10) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [rot_pkg::TOL_W-1:0] val);
        wait_drained();
        i_cfg_wdata = val;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tolerance = val;
    endtask

    function automatic logic signed [CW-1:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1, 2: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
            3: return $signed($urandom_range(0, 600)) - 300;
            4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2 ** 27)) - 2 ** 26;
        endcase
    endfunction

    function automatic logic signed [AW-1:0] pick_trig();
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return $signed($urandom_range(0, 131072)) - 65536;
    endfunction

    function automatic rot_req_t random_request();
        rot_req_t q;
        int       scale;
        for (int i = 0; i < 3; i++) begin
            q.axis[i] = pick_comp();
            q.vec[i] = pick_comp();
        end
        if ($urandom_range(0, 9) == 0) begin
            scale = $signed($urandom_range(0, 8)) - 4;
            for (int i = 0; i < 3; i++) begin
                q.axis[i] = $signed($urandom_range(0, 2000)) - 1000;
                q.vec[i] = q.axis[i] * scale + ($urandom_range(0, 3) == 0);
            end
        end else if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < 3; i++)
                q.axis[i] = $signed($urandom_range(0, 4)) - 2;
        end
        q.cos_a = pick_trig();
        q.sin_a = pick_trig();
        return q;
    endfunction

    function automatic rot_req_t make_request(input int vx, vy, vz, ax, ay, az, c, s);
        rot_req_t q;
        q.vec = '{vx, vy, vz};
        q.axis = '{ax, ay, az};
        q.cos_a = c;
        q.sin_a = s;
        return q;
    endfunction

    task automatic test_directed();
        int mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        idle_pct = 0;
        stall_pct = 0;
        send_request(make_request(65536, 0, 0, 0, 0, 65536, 0, 65536));
        send_request(make_request(65536, 131072, -65536, 65536, 65536, 65536, 46341, 46341));
        send_request(make_request(mx, mx, mx, mx, mx, mx, 65536, 65536));
        send_request(make_request(mn, mn, mn, mn, mn, mn, -65536, -65536));
        send_request(make_request(mx, mn, mx, mn, mx, mn, 0, -65536));
        send_request(make_request(mn, mx, 0, 0, mx, mn, -65536, 0));
        send_request(make_request(12345, -777, 99, 0, 0, 0, 0, 65536));
        send_request(make_request(5000, 10000, 15000, 1, 2, 3, 0, 65536));
        send_request(make_request(0, 0, 0, 7, -3, 100, 0, 65536));
        send_request(make_request(300, 200, 100, 1, 0, 0, 131071, -131072));
        send_request(make_request(mx, 0, 0, 0, mx, 0, 65536, 65536));
        send_request(make_request(-1, -1, -1, -1, -1, -1, -1, -1));
        send_request(make_request(65536, 0, 0, 0, 0, 1, 0, 65536));
        write_tolerance(0);
        send_request(make_request(5000, 10000, 15000, 1, 2, 3, 0, 65536));
        send_request(make_request(12345, -777, 99, 0, 0, 0, 0, 65536));
        send_request(make_request(65536, 0, 0, 0, 0, 1, 0, 65536));
        write_tolerance(16'hffff);
        send_request(make_request(65536, 0, 0, 0, 0, 65536, 0, 65536));
        send_request(make_request(mx, 0, 0, 0, mx, 0, 0, 65536));
        send_request(make_request(65536, 0, 0, 0, 0, 65535, 0, 65536));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) send_request(random_request());
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 400;
        repeat (250) send_request(random_request());
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_ready = $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        rot_res_t exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rotated_q.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d", o_out_x, o_out_y, o_out_z);
                errors++;
            end else begin
                exp_res = rotated_q.pop_front();
                if (o_out_x !== exp_res.comp[0]) begin
                    $error("out_x expected %0d actual %0d", exp_res.comp[0], o_out_x);
                    errors++;
                end
                if (o_out_y !== exp_res.comp[1]) begin
                    $error("out_y expected %0d actual %0d", exp_res.comp[1], o_out_y);
                    errors++;
                end
                if (o_out_z !== exp_res.comp[2]) begin
                    $error("out_z expected %0d actual %0d", exp_res.comp[2], o_out_z);
                    errors++;
                end
                if (o_passed_through !== exp_res.passed) begin
                    $error("passed_through expected %0b actual %0b",
                           exp_res.passed, o_passed_through);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(20ns * 1000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        write_tolerance(1);
        test_random(300, 0, 0);
        test_random(250, 74, 0);
        write_tolerance(300);
        test_random(250, 0, 74);
        write_tolerance($urandom_range(0, 65535));
        test_random(250, 17, 17);
        write_tolerance(0);
        test_random(100, 0, 0);
        test_backpressure();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
